### sv/dcp_pkg.sv
// ----------------------------------------------------------------------------
// dcp_pkg
// Shared types and constants for the disk CHS position unit: field widths,
// operation codes, register indexes, geometry and position records.
// ----------------------------------------------------------------------------
package dcp_pkg;

   // field widths
   localparam int CYL_W    = 12;
   localparam int HEAD_W   = 8;
   localparam int SEC_W    = 8;
   localparam int UNIT_W   = 4;
   localparam int BLOCK_W  = 28;
   localparam int ADDR_W   = 32;
   localparam int OP_W     = 2;
   localparam int TRACK_W  = HEAD_W + SEC_W;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 12;

   // disk address packing
   localparam int ADDR_UNIT_LSB = 28;
   localparam int ADDR_CYL_LSB  = 16;
   localparam int ADDR_HEAD_LSB = 8;

   // operation codes
   localparam logic [OP_W-1:0] OP_SEEK   = 2'd0;
   localparam logic [OP_W-1:0] OP_NEXT   = 2'd1;
   localparam logic [OP_W-1:0] OP_ROTATE = 2'd2;
   localparam logic [OP_W-1:0] OP_NONE   = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_CYL_COUNT  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_HEAD_COUNT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SECTORS    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_UNIT       = 2'd3;

   // geometry after reset
   localparam logic [CYL_W-1:0]   RST_CYL_COUNT  = 12'd815;
   localparam logic [HEAD_W-1:0]  RST_HEAD_COUNT = 8'd19;
   localparam logic [SEC_W-1:0]   RST_SECTORS    = 8'd17;
   localparam logic [UNIT_W-1:0]  RST_UNIT       = 4'd0;
   localparam logic [TRACK_W-1:0] RST_TRACK_SIZE = 16'd323;

   typedef struct packed {
      logic [CYL_W-1:0]   cyl_count;
      logic [HEAD_W-1:0]  head_count;
      logic [SEC_W-1:0]   sectors;
      logic [UNIT_W-1:0]  unit;
      logic [TRACK_W-1:0] track_size;  // head_count * sectors
   } geom_type;

   typedef struct packed {
      logic [CYL_W-1:0]   cylinder;
      logic [HEAD_W-1:0]  head;
      logic [SEC_W-1:0]   sector;
      logic [BLOCK_W-1:0] block;
      logic               fault;
   } pos_type;

   typedef struct packed {
      logic [OP_W-1:0]   opcode;
      logic [CYL_W-1:0]  target_cylinder;
      logic [HEAD_W-1:0] target_head;
      logic [SEC_W-1:0]  target_sector;
   } cmd_type;

   typedef struct packed {
      logic               success;
      logic               error_flag;
      logic [BLOCK_W-1:0] block_number;
      logic [ADDR_W-1:0]  disk_address;
   } result_type;

endpackage

### sv/dcp_req_if.sv
// ----------------------------------------------------------------------------
// dcp_req_if
// Command channel: valid/ready handshake carrying one position command.
// ----------------------------------------------------------------------------
interface dcp_req_if import dcp_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   opcode;
   logic [CYL_W-1:0]  target_cylinder;
   logic [HEAD_W-1:0] target_head;
   logic [SEC_W-1:0]  target_sector;

   modport source (output valid, opcode, target_cylinder, target_head, target_sector,
                   input ready);
   modport sink   (input valid, opcode, target_cylinder, target_head, target_sector,
                   output ready);
endinterface

### sv/dcp_rsp_if.sv
// ----------------------------------------------------------------------------
// dcp_rsp_if
// Result channel: valid/ready handshake carrying one operation result.
// ----------------------------------------------------------------------------
interface dcp_rsp_if import dcp_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               success;
   logic               error_flag;
   logic [BLOCK_W-1:0] block_number;
   logic [ADDR_W-1:0]  disk_address;

   modport source (output valid, success, error_flag, block_number, disk_address,
                   input ready);
   modport sink   (input valid, success, error_flag, block_number, disk_address,
                   output ready);
endinterface

### sv/dcp_seek_core.sv
// ----------------------------------------------------------------------------
// dcp_seek_core
// Next-position logic: seek, seek-next and rotate against the current
// position and geometry, block number computation and result packing.
// ----------------------------------------------------------------------------
module dcp_seek_core import dcp_pkg::*; (
   input  cmd_type    cmd,
   input  geom_type   geom,
   input  pos_type    cur,
   output pos_type    nxt,
   output result_type res
);

   logic [SEC_W:0]     sec_inc;
   logic [HEAD_W:0]    head_inc;
   logic [CYL_W:0]     cyl_inc;
   logic [CYL_W:0]     step_cyl;
   logic [HEAD_W:0]    step_head;
   logic [SEC_W:0]     step_sec;
   logic [CYL_W:0]     tgt_cyl;
   logic [HEAD_W:0]    tgt_head;
   logic [SEC_W:0]     tgt_sec;
   logic               at_target;
   logic               out_of_range;
   logic [BLOCK_W-1:0] cyl_prod;
   logic [TRACK_W-1:0] head_prod;
   logic [BLOCK_W-1:0] tgt_block;
   logic               ok;

   // widened increments so that carries are not lost
   assign sec_inc  = {1'b0, cur.sector} + 1'b1;
   assign head_inc = {1'b0, cur.head} + 1'b1;
   assign cyl_inc  = {1'b0, cur.cylinder} + 1'b1;

   // next block: carry sector into head, head into cylinder
   always_comb begin
      step_cyl  = {1'b0, cur.cylinder};
      step_head = {1'b0, cur.head};
      step_sec  = sec_inc;
      if (sec_inc == {1'b0, geom.sectors}) begin
         step_sec  = '0;
         step_head = head_inc;
         if (head_inc == {1'b0, geom.head_count}) begin
            step_head = '0;
            step_cyl  = cyl_inc;
         end
      end
   end

   // pick the seek target
   always_comb begin
      if (cmd.opcode == OP_NEXT) begin
         tgt_cyl  = step_cyl;
         tgt_head = step_head;
         tgt_sec  = step_sec;
      end else begin
         tgt_cyl  = {1'b0, cmd.target_cylinder};
         tgt_head = {1'b0, cmd.target_head};
         tgt_sec  = {1'b0, cmd.target_sector};
      end
   end

   assign at_target = (tgt_cyl == {1'b0, cur.cylinder}) && (tgt_head == {1'b0, cur.head})
                   && (tgt_sec == {1'b0, cur.sector});
   assign out_of_range = (tgt_cyl >= {1'b0, geom.cyl_count})
                      || (tgt_head >= {1'b0, geom.head_count})
                      || (tgt_sec >= {1'b0, geom.sectors});

   // linear block: two independent products and a sum
   assign cyl_prod  = BLOCK_W'(tgt_cyl[CYL_W-1:0]) * BLOCK_W'(geom.track_size);
   assign head_prod = TRACK_W'(tgt_head[HEAD_W-1:0]) * TRACK_W'(geom.sectors);
   assign tgt_block = cyl_prod + BLOCK_W'(head_prod) + BLOCK_W'(tgt_sec[SEC_W-1:0]);

   // apply the operation
   always_comb begin
      nxt = cur;
      ok  = 1'b1;
      unique case (cmd.opcode)
         OP_SEEK, OP_NEXT: begin
            if (!at_target) begin
               if (out_of_range) begin
                  nxt.fault = 1'b1;
                  ok        = 1'b0;
               end else begin
                  nxt.cylinder = tgt_cyl[CYL_W-1:0];
                  nxt.head     = tgt_head[HEAD_W-1:0];
                  nxt.sector   = tgt_sec[SEC_W-1:0];
                  nxt.block    = tgt_block;
               end
            end
         end
         OP_ROTATE: begin
            nxt.sector = (sec_inc >= {1'b0, geom.sectors}) ? '0 : sec_inc[SEC_W-1:0];
         end
         OP_NONE: begin
            nxt = cur;
         end
         default: begin
            nxt = cur;
         end
      endcase
   end

   // pack the result from the new position
   always_comb begin
      res.success      = ok;
      res.error_flag   = nxt.fault;
      res.block_number = nxt.block;
      res.disk_address = (ADDR_W'(geom.unit) << ADDR_UNIT_LSB)
                       | (ADDR_W'(nxt.cylinder) << ADDR_CYL_LSB)
                       | (ADDR_W'(nxt.head) << ADDR_HEAD_LSB)
                       | ADDR_W'(nxt.sector);
   end

endmodule

### sv/disk_chs_position_unit_top.sv
// ----------------------------------------------------------------------------
// disk_chs_position_unit_top
// Disk unit position tracker: cylinder/head/sector position, linear block
// number and sticky seek-error flag, with a configurable drive geometry.
// ----------------------------------------------------------------------------
//   channel   direction  handshake              payload
//   req_bus   in         valid/ready            opcode, target C/H/S
//   rsp_bus   out        valid/ready            success, error, block, address
//   csr_*     in         csr_wr_en, no stall    csr_index, csr_wr_data
//
// One beat per cycle unless the result stalls; commands pass the command
// register, then the result register, with the position update between
// them, so the next command sees the new position with no gap. A stalled
// result is held and the command stage keeps accepting until both are full.
// Reset (synchronous, active high) restores the default geometry and clears
// the position, block number and error flag.
// ----------------------------------------------------------------------------
module disk_chs_position_unit_top import dcp_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   dcp_req_if.sink               req_bus,
   dcp_rsp_if.source             rsp_bus,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);

   geom_type   geom_ff, geom_in;
   pos_type    pos_ff, pos_in;
   cmd_type    cmd_ff, cmd_in;
   logic       cmd_valid_ff, cmd_valid_in;
   result_type rsp_ff, rsp_in;
   logic       rsp_valid_ff, rsp_valid_in;
   pos_type    core_pos;
   result_type core_res;
   logic       rsp_open;
   logic       core_fire;
   logic       req_fire;

   // handshake control
   assign rsp_open      = !rsp_valid_ff || rsp_bus.ready;
   assign core_fire     = cmd_valid_ff && rsp_open;
   assign req_bus.ready = !cmd_valid_ff || rsp_open;
   assign req_fire      = req_bus.valid && req_bus.ready;

   // configuration writes; keep the track size product alongside
   always_comb begin
      geom_in = geom_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            REG_CYL_COUNT: begin
               geom_in.cyl_count = csr_wr_data[CYL_W-1:0];
            end
            REG_HEAD_COUNT: begin
               geom_in.head_count = csr_wr_data[HEAD_W-1:0];
               geom_in.track_size = TRACK_W'(csr_wr_data[HEAD_W-1:0])
                                  * TRACK_W'(geom_ff.sectors);
            end
            REG_SECTORS: begin
               geom_in.sectors    = csr_wr_data[SEC_W-1:0];
               geom_in.track_size = TRACK_W'(geom_ff.head_count)
                                  * TRACK_W'(csr_wr_data[SEC_W-1:0]);
            end
            REG_UNIT: begin
               geom_in.unit = csr_wr_data[UNIT_W-1:0];
            end
            default: begin
               geom_in = geom_ff;
            end
         endcase
      end
   end

   // command stage: load on a beat, drop once passed on
   always_comb begin
      cmd_in                 = cmd_ff;
      cmd_valid_in           = cmd_valid_ff && !core_fire;
      if (req_fire) begin
         cmd_in.opcode          = req_bus.opcode;
         cmd_in.target_cylinder = req_bus.target_cylinder;
         cmd_in.target_head     = req_bus.target_head;
         cmd_in.target_sector   = req_bus.target_sector;
         cmd_valid_in           = 1'b1;
      end
   end

   dcp_seek_core u_core (
      .cmd  (cmd_ff),
      .geom (geom_ff),
      .cur  (pos_ff),
      .nxt  (core_pos),
      .res  (core_res)
   );

   // advance position and result together
   assign pos_in       = core_fire ? core_pos : pos_ff;
   assign rsp_in       = core_fire ? core_res : rsp_ff;
   assign rsp_valid_in = core_fire || (rsp_valid_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         geom_ff.cyl_count  <= RST_CYL_COUNT;
         geom_ff.head_count <= RST_HEAD_COUNT;
         geom_ff.sectors    <= RST_SECTORS;
         geom_ff.unit       <= RST_UNIT;
         geom_ff.track_size <= RST_TRACK_SIZE;
         pos_ff             <= '0;
         cmd_valid_ff       <= 1'b0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         geom_ff            <= geom_in;
         pos_ff             <= pos_in;
         cmd_valid_ff       <= cmd_valid_in;
         rsp_valid_ff       <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.success      = rsp_ff.success;
   assign rsp_bus.error_flag   = rsp_ff.error_flag;
   assign rsp_bus.block_number = rsp_ff.block_number;
   assign rsp_bus.disk_address = rsp_ff.disk_address;

`ifndef SYNTHESIS
   // the seek error flag is sticky until reset
   a_fault_sticky: assert property (@(posedge clock) disable iff (reset)
      (!reset && pos_ff.fault) |=> pos_ff.fault)
      else $error("seek error flag cleared without reset");

   // position moves only when a command is processed
   a_pos_hold: assert property (@(posedge clock) disable iff (reset)
      (!reset && !core_fire) |=> $stable(pos_ff))
      else $error("position changed with no command processed");

   // a failed operation always reports the error flag
   a_fail_flag: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && !rsp_bus.success) |-> rsp_bus.error_flag)
      else $error("failed result without error flag");

   // a stalled result is never overwritten by the command stage
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_bus.ready) |-> !core_fire)
      else $error("result register overwritten while stalled");
`endif

endmodule
